// File: rtl/assert_macros.svh
// Assertion macros shared by the list table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DLT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define DLT_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define DLT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/dlt_pkg.sv
// Types, codes and constants shared by the list table modules.
package dlt_pkg;

  localparam int unsigned DefaultCapacity = 64;

  localparam int unsigned OpW     = 3;
  localparam int unsigned OrdW    = 7;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_INS_LEFT_END  = 3'd0,
    OP_INS_RIGHT_END = 3'd1,
    OP_DELETE        = 3'd2,
    OP_INS_LEFT_OF   = 3'd3,
    OP_INS_RIGHT_OF  = 3'd4,
    OP_READ_OUT      = 3'd5
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  // Kind of result the datapath forms when the controller loads the output.
  typedef enum logic [2:0] {
    RESP_OK,
    RESP_FULL,
    RESP_BAD,
    RESP_INS,
    RESP_ELEM
  } resp_e;

  typedef struct packed {
    logic [OpW-1:0]         opcode;
    logic [OrdW-1:0]        ordinal;
    logic signed [ValW-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0]     status;
    logic [OrdW-1:0]        node_ordinal;
    logic signed [ValW-1:0] element_value;
    logic                   is_element;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic  capture;
    logic  decode;
    logic  load_links;
    logic  wr_node;
    logic  wr_nbr;
    logic  walk_rd;
    logic  walk_step;
    logic  out_load;
    resp_e resp;
  } dlt_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           ord_live;
    logic           full;
    logic           list_empty;
    logic           walk_last;
    logic           out_free;
  } dlt_status_t;

endpackage

// File: rtl/dlt_ram.sv
// Generic memory with one write port and one registered read port.
module dlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dlt_ctrl.sv
// Controller state machine that sequences list operations.
`include "assert_macros.svh"

module dlt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dlt_pkg::dlt_status_t status_i,
  output dlt_pkg::dlt_cmd_t    cmd_o
);
  import dlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_WR_NODE,
    S_WR_NBR,
    S_RESP,
    S_WALK_RD,
    S_WALK_EMIT
  } state_e;

  state_e state_q, state_d;
  resp_e  resp_q, resp_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    cmd_o   = '0;
    cmd_o.resp = resp_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        case (status_i.op)
          OP_READ_OUT: begin
            resp_d  = RESP_OK;
            state_d = status_i.list_empty ? S_RESP : S_WALK_RD;
          end
          OP_DELETE: begin
            if (!status_i.ord_live) begin
              resp_d  = RESP_BAD;
              state_d = S_RESP;
            end else begin
              resp_d  = RESP_OK;
              state_d = S_LOAD;
            end
          end
          OP_INS_LEFT_OF, OP_INS_RIGHT_OF: begin
            if (!status_i.ord_live) begin
              resp_d  = RESP_BAD;
              state_d = S_RESP;
            end else if (status_i.full) begin
              resp_d  = RESP_FULL;
              state_d = S_RESP;
            end else begin
              resp_d  = RESP_INS;
              state_d = S_LOAD;
            end
          end
          OP_INS_LEFT_END, OP_INS_RIGHT_END: begin
            if (status_i.full) begin
              resp_d  = RESP_FULL;
              state_d = S_RESP;
            end else begin
              resp_d  = RESP_INS;
              state_d = S_WR_NODE;
            end
          end
          default: begin
            resp_d  = RESP_OK;
            state_d = S_RESP;
          end
        endcase
      end
      S_LOAD: begin
        cmd_o.load_links = 1'b1;
        state_d = (status_i.op == OP_DELETE) ? S_WR_NBR : S_WR_NODE;
      end
      S_WR_NODE: begin
        cmd_o.wr_node = 1'b1;
        state_d       = S_WR_NBR;
      end
      S_WR_NBR: begin
        cmd_o.wr_nbr = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = S_WALK_EMIT;
      end
      S_WALK_EMIT: begin
        cmd_o.resp = RESP_ELEM;
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.walk_step = 1'b1;
          state_d = status_i.walk_last ? S_IDLE : S_WALK_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= RESP_OK;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  `DLT_ASSERT_IMPL(a_out_load_free, cmd_o.out_load, status_i.out_free, "output loaded while occupied")
  `DLT_ASSERT_IMPL(a_nbr_order, state_q == S_WR_NBR, $past(state_q) == S_WR_NODE || $past(state_q) == S_LOAD, "neighbor write out of order")

endmodule

// File: rtl/dlt_datapath.sv
// Datapath: link and value memories, sentinel links, live marks and output register.
`include "assert_macros.svh"

module dlt_datapath #(
  parameter int unsigned CAPACITY = dlt_pkg::DefaultCapacity
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dlt_pkg::in_item_t    in_data_i,
  input  dlt_pkg::dlt_cmd_t    cmd_i,
  output dlt_pkg::dlt_status_t status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output dlt_pkg::out_item_t   out_data_o
);
  import dlt_pkg::*;

  localparam int unsigned NW = $clog2(CAPACITY + 2);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [NW-1:0] NodeLeft  = '0;
  localparam logic [NW-1:0] NodeRight = NW'(1);

  logic [OpW-1:0]         op_q;
  logic [OrdW-1:0]        ord_q;
  logic signed [ValW-1:0] val_q;
  logic [NW-1:0]          anchor_q, next_q, cur_q;
  logic [NW-1:0]          head_q, tail_q;
  logic [CW-1:0]          cnt_q;
  logic [CAPACITY-1:0]    live_q;
  logic                   out_valid_q;
  out_item_t              out_q, out_d;

  logic [IW-1:0] ord_idx, cnt_idx, cur_idx, next_idx, anchor_idx;
  logic [NW-1:0] new_node, ord_node;
  logic          is_del;

  logic          left_we, right_we, value_we;
  logic [IW-1:0] left_waddr, right_waddr;
  logic [NW-1:0] left_wdata, right_wdata;
  logic          left_re, right_re, value_re;
  logic [IW-1:0] right_raddr;
  logic [NW-1:0] left_rdata, right_rdata;
  logic [ValW-1:0] value_rdata;

  assign ord_idx    = IW'(ord_q - OrdW'(1));
  assign cnt_idx    = cnt_q[IW-1:0];
  assign cur_idx    = IW'(cur_q - NW'(2));
  assign next_idx   = IW'(next_q - NW'(2));
  assign anchor_idx = IW'(anchor_q - NW'(2));
  assign new_node   = NW'(cnt_q) + NW'(2);
  assign ord_node   = NW'(ord_q) + NW'(1);
  assign is_del     = (op_q == OP_DELETE);

  always_comb begin
    left_we     = 1'b0;
    left_waddr  = cnt_idx;
    left_wdata  = anchor_q;
    right_we    = 1'b0;
    right_waddr = cnt_idx;
    right_wdata = next_q;
    value_we    = 1'b0;
    if (cmd_i.wr_node) begin
      left_we  = 1'b1;
      right_we = 1'b1;
      value_we = 1'b1;
    end else if (cmd_i.wr_nbr) begin
      left_we     = (next_q != NodeRight);
      left_waddr  = next_idx;
      left_wdata  = is_del ? anchor_q : new_node;
      right_we    = (anchor_q != NodeLeft);
      right_waddr = anchor_idx;
      right_wdata = is_del ? next_q : new_node;
    end
  end

  assign left_re     = cmd_i.decode;
  assign right_re    = cmd_i.decode | cmd_i.walk_rd;
  assign right_raddr = cmd_i.walk_rd ? cur_idx : ord_idx;
  assign value_re    = cmd_i.walk_rd;

  dlt_ram #(.Width(NW), .Depth(CAPACITY)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (left_wdata),
    .re_i    (left_re),
    .raddr_i (ord_idx),
    .rdata_o (left_rdata)
  );

  dlt_ram #(.Width(NW), .Depth(CAPACITY)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (right_wdata),
    .re_i    (right_re),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  dlt_ram #(.Width(ValW), .Depth(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (value_we),
    .waddr_i (cnt_idx),
    .wdata_i (val_q),
    .re_i    (value_re),
    .raddr_i (cur_idx),
    .rdata_o (value_rdata)
  );

  // Result formed at the moment the controller loads the output register.
  always_comb begin
    out_d      = '0;
    out_d.last = 1'b1;
    case (cmd_i.resp)
      RESP_FULL: out_d.status = STATUS_FULL;
      RESP_BAD:  out_d.status = STATUS_BAD;
      RESP_INS:  out_d.node_ordinal = OrdW'(cnt_q);
      RESP_ELEM: begin
        out_d.node_ordinal  = OrdW'(cur_q) - OrdW'(1);
        out_d.element_value = value_rdata;
        out_d.is_element    = 1'b1;
        out_d.last          = (right_rdata == NodeRight);
      end
      default: out_d.status = STATUS_OK;
    endcase
  end

  assign status_o.op         = op_q;
  assign status_o.ord_live   = (ord_q != '0) && (ord_q <= OrdW'(cnt_q)) && live_q[ord_idx];
  assign status_o.full       = (cnt_q == CW'(CAPACITY));
  assign status_o.list_empty = (head_q == NodeRight);
  assign status_o.walk_last  = (right_rdata == NodeRight);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NodeRight;
      tail_q      <= NodeLeft;
      cnt_q       <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_node) begin
        live_q[cnt_idx] <= 1'b1;
      end
      if (cmd_i.wr_nbr) begin
        if (next_q == NodeRight) begin
          tail_q <= left_wdata;
        end
        if (anchor_q == NodeLeft) begin
          head_q <= right_wdata;
        end
        if (is_del) begin
          live_q[ord_idx] <= 1'b0;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_data_i.opcode;
      ord_q <= in_data_i.ordinal;
      val_q <= in_data_i.item_value;
    end
    if (cmd_i.decode) begin
      cur_q <= head_q;
      case (op_q)
        OP_INS_LEFT_END: begin
          anchor_q <= NodeLeft;
          next_q   <= head_q;
        end
        OP_INS_RIGHT_END: begin
          anchor_q <= tail_q;
          next_q   <= NodeRight;
        end
        OP_INS_LEFT_OF:  next_q   <= ord_node;
        OP_INS_RIGHT_OF: anchor_q <= ord_node;
        default: ;
      endcase
    end
    if (cmd_i.load_links) begin
      case (op_q)
        OP_DELETE: begin
          anchor_q <= left_rdata;
          next_q   <= right_rdata;
        end
        OP_INS_LEFT_OF:  anchor_q <= left_rdata;
        OP_INS_RIGHT_OF: next_q   <= right_rdata;
        default: ;
      endcase
    end
    if (cmd_i.walk_step) begin
      cur_q <= right_rdata;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DLT_ASSERT(a_ends_agree, (head_q == NodeRight) == (tail_q == NodeLeft), "head and tail disagree on empty list")
  `DLT_ASSERT_IMPL(a_new_slot_free, cmd_i.wr_node, !live_q[cnt_idx], "new node slot already live")
  `DLT_ASSERT_NEXT(a_count_step, cmd_i.wr_nbr && !is_del, cnt_q == CW'($past(cnt_q) + CW'(1)), "insert did not advance count")

endmodule

// File: rtl/doubly_linked_list_table.sv
// Top level of the doubly linked list table: controller, datapath and ports.
// The block keeps a doubly linked list of up to CAPACITY signed 32-bit values
// between two fixed sentinel ends. Every node is named by its insertion ordinal
// (1 for the first value ever inserted), and slots are never reused, so once
// CAPACITY inserts have been taken every further insert reports full. Each
// input transfer carries one command: insert at the left or right end, insert
// to the left or right of a live node, delete a live node, or read the whole
// list out. Inserts and deletes give exactly one output transfer with last set;
// a successful insert returns the new ordinal, and a dead or out-of-range
// ordinal returns the bad-ordinal status without touching the list (checked
// before fullness). A read out gives one output transfer per element from left
// to right, with last on the final element, or a single empty transfer for an
// empty list; unused opcodes give one all-zero transfer with last set. The
// block works on one command at a time and takes a new input transfer only
// while its controller is idle, but it does so even while the previous result
// still waits in the output register. After the accept and decode steps, an
// insert at either end writes the new node and then its neighbors; an insert
// beside a node and a delete first load the named node's links, and a delete
// writes only the neighbors. Each link memory has a single write port, so the
// node write and the neighbor writes are separate steps. A read out alternates
// a read step and an emit step per element, since the next link comes from the
// registered-read memory. Output stalls hold the result or emit step. Both the
// link and value memories start undefined and need no clearing pass; the
// sentinel links live in flip-flops and reset with the block.
module doubly_linked_list_table #(
  parameter int unsigned CAPACITY = dlt_pkg::DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dlt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dlt_pkg::out_item_t out_data_o
);
  import dlt_pkg::*;

  dlt_cmd_t    cmd;
  dlt_status_t status;

  // The controller decides the sequence of memory steps; it never sees data.
  dlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the list storage and the output register.
  dlt_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: bench/doubly_linked_list_table_test.sv
// Self-checking testbench for the doubly linked list table with its own list predictor.
module doubly_linked_list_table_test;
  import dlt_pkg::*;

  // The block under test keeps up to Cap nodes between a left end node and a right end node.
  // Nodes are named by insertion ordinal, and node k sits in link slot k+1.
  localparam int unsigned Cap = DefaultCapacity;
  localparam logic [OrdW-1:0] LeftEnd = 7'd0;
  localparam logic [OrdW-1:0] RightEnd = 7'd1;

  // Opcodes 6 and 7 are not decoded by the block. Each one still gives one all-zero result with last set.
  localparam logic [OpW-1:0] OpUnusedLow = 3'd6;
  localparam logic [OpW-1:0] OpUnusedHigh = 3'd7;

  // The longest quiet stretch in a correct run covers a long input gap, the work on
  // one command and a long output stall. The watchdog allows many times that.
  localparam int IdleLimit = 2000;
  localparam int TailCycles = 32;
  localparam int ReportLimit = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  doubly_linked_list_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // The predictor keeps its own copy of the list. Values are stored by ordinal-1. The link
  // tables are indexed by node slot, and the live marks are indexed by ordinal-1.
  logic signed [ValW-1:0] node_value [Cap];
  logic [OrdW-1:0]        left_of [Cap+2];
  logic [OrdW-1:0]        right_of [Cap+2];
  bit                     is_live [Cap];
  int                     insert_total;

  // These are the results still owed by the block, oldest first.
  out_item_t pending_results [$];

  // These counters are used by the checker and by the closing summary.
  int mismatch_count;
  int results_checked;
  int commands_sent;
  int readouts_sent;
  int elements_expected;
  int full_expected;
  int bad_expected;

  // When this flag is set, both sides run without idling.
  bit no_stall;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Most gaps are zero or short. A few gaps are long enough to back up the
  // other side.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_stall || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // When want_live is set, this returns a random live ordinal, or 0 if none is live.
  // Otherwise it returns an ordinal the block must reject. That is a deleted node if there
  // is one, else an ordinal beyond the insert count.
  function automatic logic [OrdW-1:0] pick_ordinal(bit want_live);
    int hits;
    int pick;
    hits = 0;
    for (int i = 0; i < insert_total; i++) if (is_live[i] == want_live) hits++;
    if (hits == 0) begin
      if (want_live || insert_total >= 127) return '0;
      return OrdW'($urandom_range(insert_total + 1, 127));
    end
    pick = $urandom_range(0, hits - 1);
    for (int i = 0; i < insert_total; i++) begin
      if (is_live[i] == want_live) begin
        if (pick == 0) return OrdW'(i + 1);
        pick--;
      end
    end
    return '0;
  endfunction

  function automatic bit ordinal_is_live(logic [OrdW-1:0] ord);
    if (ord == 0 || ord > insert_total) return 1'b0;
    return is_live[ord - 1];
  endfunction

  function automatic out_item_t make_result(status_e st, logic [OrdW-1:0] ord,
                                            logic signed [ValW-1:0] value, logic elem,
                                            logic fin);
    out_item_t res;
    res.status        = st;
    res.node_ordinal  = ord;
    res.element_value = value;
    res.is_element    = elem;
    res.last          = fin;
    return res;
  endfunction

  // This applies one accepted command to the predicted list and queues the results the
  // block owes for it.
  task automatic predict_list_update(in_item_t cmd);
    logic [OrdW-1:0] node;
    logic [OrdW-1:0] next_node;
    logic [OrdW-1:0] anchor;
    logic [OrdW-1:0] slot;
    int              walked;
    case (cmd.opcode)
      OP_READ_OUT: begin
        // The walk goes from the left end to the right end and stops after Cap elements.
        readouts_sent++;
        node   = right_of[LeftEnd];
        walked = 0;
        while (node != RightEnd && walked < Cap) begin
          next_node = right_of[node];
          pending_results.push_back(make_result(STATUS_OK, node - 7'd1, node_value[node - 2],
                                                1'b1, next_node == RightEnd || walked == Cap - 1));
          elements_expected++;
          walked++;
          node = next_node;
        end
        if (walked == 0) pending_results.push_back(make_result(STATUS_OK, '0, '0, 1'b0, 1'b1));
      end
      OP_DELETE: begin
        if (!ordinal_is_live(cmd.ordinal)) begin
          bad_expected++;
          pending_results.push_back(make_result(STATUS_BAD, '0, '0, 1'b0, 1'b1));
        end else begin
          node = cmd.ordinal + 7'd1;
          right_of[left_of[node]] = right_of[node];
          left_of[right_of[node]] = left_of[node];
          is_live[cmd.ordinal - 1] = 1'b0;
          pending_results.push_back(make_result(STATUS_OK, '0, '0, 1'b0, 1'b1));
        end
      end
      OP_INS_LEFT_END, OP_INS_RIGHT_END, OP_INS_LEFT_OF, OP_INS_RIGHT_OF: begin
        // A dead anchor is reported before fullness.
        if ((cmd.opcode == OP_INS_LEFT_OF || cmd.opcode == OP_INS_RIGHT_OF) &&
            !ordinal_is_live(cmd.ordinal)) begin
          bad_expected++;
          pending_results.push_back(make_result(STATUS_BAD, '0, '0, 1'b0, 1'b1));
        end else if (insert_total >= Cap) begin
          full_expected++;
          pending_results.push_back(make_result(STATUS_FULL, '0, '0, 1'b0, 1'b1));
        end else begin
          // The new node always goes to the right of an anchor node.
          case (cmd.opcode)
            OP_INS_LEFT_END:  anchor = LeftEnd;
            OP_INS_RIGHT_END: anchor = left_of[RightEnd];
            OP_INS_LEFT_OF:   anchor = left_of[cmd.ordinal + 7'd1];
            default:          anchor = cmd.ordinal + 7'd1;
          endcase
          slot = OrdW'(insert_total + 2);
          node_value[insert_total] = cmd.item_value;
          is_live[insert_total]    = 1'b1;
          left_of[slot]            = anchor;
          right_of[slot]           = right_of[anchor];
          left_of[right_of[anchor]] = slot;
          right_of[anchor]         = slot;
          insert_total++;
          pending_results.push_back(make_result(STATUS_OK, OrdW'(insert_total), '0, 1'b0,
                                                1'b1));
        end
      end
      default: begin
        // An unused opcode leaves the list unchanged.
        pending_results.push_back(make_result(STATUS_OK, '0, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  // This offers one command after a random gap and holds it until the block accepts it.
  // Valid stays high across back-to-back transfers, so it is lowered only when a gap
  // comes first.
  task automatic send_command(logic [OpW-1:0] op, logic [OrdW-1:0] ord,
                              logic signed [ValW-1:0] value);
    int       gap;
    in_item_t cmd;
    gap = pick_gap();
    cmd.opcode     = op;
    cmd.ordinal    = ord;
    cmd.item_value = value;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    commands_sent++;
    predict_list_update(cmd);
  endtask

  // An empty list: read out, deletes of ordinals never inserted, inserts beside missing
  // nodes, and both unused opcodes.
  task automatic test_empty_list();
    send_command(OP_READ_OUT, '0, '0);
    send_command(OP_DELETE, 7'd0, '0);
    send_command(OP_DELETE, 7'd1, '0);
    send_command(OP_INS_LEFT_OF, 7'd1, 32'sd5);
    send_command(OP_INS_RIGHT_OF, 7'd127, 32'sd6);
    send_command(OpUnusedLow, '0, '0);
    send_command(OpUnusedHigh, '1, '1);
  endtask

  // Inserts at both ends with the extreme values, then a read out.
  task automatic test_end_inserts();
    send_command(OP_INS_LEFT_END, '0, 32'sh7fffffff);
    send_command(OP_INS_RIGHT_END, '0, 32'sh80000000);
    send_command(OP_INS_LEFT_END, '1, -32'sd1);
    send_command(OP_INS_RIGHT_END, '0, 32'sd0);
    send_command(OP_READ_OUT, '0, '0);
  endtask

  // Inserts beside inner nodes and beside the nodes next to either end.
  task automatic test_neighbor_inserts();
    send_command(OP_INS_LEFT_OF, 7'd2, 32'sh0000_1234);
    send_command(OP_INS_RIGHT_OF, 7'd3, 32'shdead_beef);
    send_command(OP_INS_LEFT_OF, 7'd3, 32'sh5555_5555);
    send_command(OP_INS_RIGHT_OF, 7'd4, 32'shaaaa_aaaa);
    send_command(OP_READ_OUT, '0, '0);
  endtask

  // Deletes of a live node, of the same node again, and of the leftmost node. Then an
  // insert beside a deleted node.
  task automatic test_delete();
    send_command(OP_DELETE, 7'd1, '0);
    send_command(OP_DELETE, 7'd1, '0);
    send_command(OP_DELETE, 7'd7, '0);
    send_command(OP_INS_LEFT_OF, 7'd7, 32'sd99);
    send_command(OP_READ_OUT, '0, '0);
  endtask

  // Random traffic. Most commands are well formed and aim at live nodes. The rest are
  // dead or out-of-range ordinals and unused opcodes. Once every slot has been used,
  // inserts report full.
  task automatic test_random_traffic(int commands, int insert_pct, bit quiet);
    int              roll;
    logic [OpW-1:0]  op;
    logic [OrdW-1:0] ord;
    no_stall = quiet;
    repeat (commands) begin
      roll = $urandom_range(0, 99);
      ord  = OrdW'($urandom_range(0, 127));
      if (roll < insert_pct) begin
        case ($urandom_range(0, 3))
          0:       op = OP_INS_LEFT_END;
          1:       op = OP_INS_RIGHT_END;
          2:       op = OP_INS_LEFT_OF;
          default: op = OP_INS_RIGHT_OF;
        endcase
        if ($urandom_range(0, 9) != 0 && pick_ordinal(1'b1) != 0) ord = pick_ordinal(1'b1);
      end else if (roll < insert_pct + 22) begin
        op = OP_DELETE;
        if ($urandom_range(0, 6) != 0 && pick_ordinal(1'b1) != 0) ord = pick_ordinal(1'b1);
      end else if (roll < insert_pct + 32) begin
        op = OP_READ_OUT;
      end else if (roll < insert_pct + 40) begin
        op  = $urandom_range(0, 1) ? OP_INS_LEFT_OF : OP_INS_RIGHT_OF;
        ord = pick_ordinal(1'b0);
      end else if (roll < insert_pct + 46) begin
        op = OP_DELETE;
        ord = pick_ordinal(1'b0);
      end else begin
        op = $urandom_range(0, 1) ? OpUnusedLow : OpUnusedHigh;
      end
      send_command(op, ord, $urandom);
    end
    no_stall = 1'b0;
  endtask

  // The output side drops ready for random stretches. A stall never starts while the
  // no-stall flag is set.
  initial begin : result_drain
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(string field_name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("result %0d: %s expected %0h, got %0h", results_checked, field_name, want,
                 got);
    end
  endtask

  // Each output transfer is compared with the oldest pending result. A transfer that
  // arrives when nothing is owed is a failure in its own right.
  always @(posedge clk_i) begin : result_checker
    out_item_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected result %0h with nothing pending", out_data_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("node_ordinal", 32'(want.node_ordinal), 32'(out_data_o.node_ordinal));
        check_field("element_value", want.element_value, out_data_o.element_value);
        check_field("is_element", 32'(want.is_element), 32'(out_data_o.is_element));
        check_field("last", 32'(want.last), 32'(out_data_o.last));
      end
      results_checked++;
    end
  end

  // The watchdog ends a hung run. It counts cycles in which neither channel completes
  // a transfer.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready_i === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("no transfer for %0d cycles, %0d results still pending", IdleLimit,
             pending_results.size());
    $display("doubly_linked_list_table_test NOT OK");
    $finish;
  end

  initial begin : run_tests
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    no_stall   = 1'b0;
    mismatch_count    = 0;
    results_checked   = 0;
    commands_sent     = 0;
    readouts_sent     = 0;
    elements_expected = 0;
    full_expected     = 0;
    bad_expected      = 0;
    // After reset the list is empty, with the two end nodes pointing at each other.
    insert_total = 0;
    for (int i = 0; i < Cap; i++) begin
      node_value[i] = '0;
      is_live[i]    = 1'b0;
    end
    for (int i = 0; i < Cap + 2; i++) begin
      left_of[i]  = '0;
      right_of[i] = '0;
    end
    right_of[LeftEnd] = RightEnd;
    left_of[RightEnd] = LeftEnd;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_end_inserts();
    test_neighbor_inserts();
    test_delete();
    // First the list grows until every slot is used. Then a stretch runs with no idling,
    // and after that the list mostly shrinks while inserts report full.
    test_random_traffic(150, 55, 1'b0);
    test_random_traffic(60, 30, 1'b1);
    test_random_traffic(240, 20, 1'b0);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d commands with %0d read outs: %0d inserts, %0d full, %0d bad ordinal.",
             commands_sent, readouts_sent, insert_total, full_expected, bad_expected);
    $display("Checked %0d results including %0d list elements; %0d mismatches.",
             results_checked, elements_expected, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("doubly_linked_list_table_test OK");
    end else begin
      $display("doubly_linked_list_table_test NOT OK");
    end
    $finish;
  end

endmodule
